### design/bounded_double_ended_queue_assert.svh
// ----------------------------------------------------------------------------
// Bounded double-ended queue assertion macros
// Concurrent assertion wrappers for the queue; empty when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define BDQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdq assertion failed: same-cycle implication");

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdq assertion failed: next-cycle implication");

`else

`define BDQ_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define BDQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### design/bdq_pkg.sv
// ----------------------------------------------------------------------------
// Bounded double-ended queue package
// Action and status codes, default depth and the beat payload types.
// ----------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH_DEFAULT = 32;
   localparam int DATA_W        = 32;
   localparam int ACTION_W      = 3;
   localparam int STATUS_W      = 2;

   localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_DISPLAY    = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] item_value;
      logic [STATUS_W-1:0]      status;
      logic                     last;
   } rsp_type;

endpackage

### design/bdq_ram.sv
// ----------------------------------------------------------------------------
// Bounded double-ended queue entry RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/bounded_double_ended_queue.sv
// ----------------------------------------------------------------------------
// Bounded double-ended queue
// Ring of DEPTH signed entries in a RAM with a front index and entry count.
// ----------------------------------------------------------------------------
// channel  ports                       handshake
// request  start, busy, req_payload    beat taken when start and not busy
// response rsp_valid, rsp_payload      one-cycle strobe, no back-pressure
//
// Push: busy stays low. Pop: busy through state S_POP while the RAM read
// completes. Display of N entries: one RAM read per entry on the single
// read port. Empty and full give a status response; unused actions give none.
// Synchronous reset empties the queue; RAM contents are not cleared.
// The response side cannot stall; each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
`include "bounded_double_ended_queue_assert.svh"

module bounded_double_ended_queue import bdq_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_payload,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_DISP = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] offset_ff, offset_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic              accept;
   logic              full;
   logic              empty;
   logic              is_push;
   logic [CNT_W-1:0]  ring_off;
   logic [CNT_W:0]    ring_sum;
   logic [CNT_W:0]    ring_wrap;
   logic [IDX_W-1:0]  ring_pos;
   logic [IDX_W-1:0]  front_dec;
   logic [IDX_W-1:0]  front_inc;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign full    = (count_ff == DEPTH_CNT);
   assign empty   = (count_ff == '0);
   assign is_push = (req_payload.action == ACT_PUSH_FRONT) ||
                    (req_payload.action == ACT_PUSH_BACK);

   // position offset places after the front, wrapped round the ring
   always_comb begin
      if (state_ff == S_DISP) begin
         ring_off = offset_ff;
      end else if (req_payload.action == ACT_POP_BACK) begin
         ring_off = count_ff - 1'b1;
      end else begin
         ring_off = count_ff;
      end
   end

   assign ring_sum  = (CNT_W + 1)'(front_ff) + (CNT_W + 1)'(ring_off);
   assign ring_wrap = (ring_sum >= DEPTH_SUM) ? ring_sum - DEPTH_SUM : ring_sum;
   assign ring_pos  = ring_wrap[IDX_W-1:0];
   assign front_dec = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign front_inc = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;

   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      offset_in    = offset_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = ring_pos;
      rd_en        = 1'b0;
      rd_addr      = ring_pos;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_payload.action)
                  ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in = '{item_value: '0, status: ST_FULL, last: 1'b1};
                     end else begin
                        wr_en = 1'b1;
                        if (req_payload.action == ACT_PUSH_FRONT) begin
                           wr_addr  = front_dec;
                           front_in = front_dec;
                        end
                        count_in = count_ff + 1'b1;
                        rsp_in   = '{item_value: '0, status: ST_OK, last: 1'b1};
                     end
                  end
                  ACT_POP_FRONT, ACT_POP_BACK: begin
                     if (empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{item_value: '0, status: ST_EMPTY, last: 1'b1};
                     end else begin
                        rd_en = 1'b1;
                        if (req_payload.action == ACT_POP_FRONT) begin
                           rd_addr  = front_ff;
                           front_in = front_inc;
                        end
                        count_in = count_ff - 1'b1;
                        state_in = S_POP;
                     end
                  end
                  ACT_DISPLAY: begin
                     if (empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{item_value: '0, status: ST_EMPTY, last: 1'b1};
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = front_ff;
                        offset_in = CNT_W'(1);
                        state_in  = S_DISP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{item_value: signed'(rd_data), status: ST_OK, last: 1'b1};
            state_in     = S_IDLE;
         end
         S_DISP: begin
            rsp_valid_in = 1'b1;
            rsp_in       = '{item_value: signed'(rd_data), status: ST_OK,
                             last: (offset_ff == count_ff)};
            if (offset_ff == count_ff) begin
               state_in = S_IDLE;
            end else begin
               rd_en     = 1'b1;
               offset_in = offset_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   bdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `BDQ_ASSERT_NEXT(a_pop_result, clock, reset, state_ff == S_POP, rsp_valid && rsp_payload.last)
   `BDQ_ASSERT_NEXT(a_disp_result, clock, reset, state_ff == S_DISP, rsp_valid)
   `BDQ_ASSERT_NEXT(a_push_count, clock, reset, accept && is_push && !full, count_ff == $past(count_ff) + 1'b1)
   `BDQ_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT)

endmodule
